@@ hw/rtl/sps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the shift-patch mode selector.
// No dependencies; every other file of the block but sps_ram imports this package.
package sps_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int NUM_SHIFTS  = 13;
    localparam int WIN_ROWS    = 5;
    localparam int WIN_COLS    = 5;

    localparam int PX_W   = 8;
    localparam int CFG_W  = 9;
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int RD_W   = POS_W + 1;
    localparam int CNT_W  = 17;
    localparam int COST_W = 20;
    localparam int OUT_W  = 17;
    localparam int K_W    = $clog2(NUM_SHIFTS);
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int NEW_SHIFT_OVERHEAD = 5;
    localparam int CONT_OVERHEAD      = 1;

    // Candidate order: (0,0),(1,0),(-1,0),(0,1),(0,-1),(1,1),(1,-1),(-1,1),(-1,-1),
    // (2,0),(-2,0),(0,2),(0,-2).
    localparam int SHIFT_DX_I [NUM_SHIFTS] = '{0, 1, -1, 0, 0, 1, 1, -1, -1, 2, -2, 0, 0};
    localparam int SHIFT_DY_I [NUM_SHIFTS] = '{0, 0, 0, 1, -1, 1, -1, 1, -1, 0, 0, 2, -2};

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_SHIFT = 2'd1,
        MODE_CONT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SEL_IDLE,
        SEL_SWEEP,
        SEL_DONE
    } sel_state_t;

    // Context of one pixel as it reaches the compare stage.
    typedef struct packed {
        logic              valid;
        logic              hp;
        logic [PX_W-1:0]   px;
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
        logic [POS_W-1:0]  pos;
        logic [XW-1:0]     wm1;
        logic [YW-1:0]     hm1;
    } pix_ctx_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [CNT_W-1:0]  count;
    } cand_tot_t;

    typedef struct packed {
        mode_t             mode;
        logic signed [2:0] sx;
        logic signed [2:0] sy;
        logic [OUT_W-1:0]  bytes;
        logic [CNT_W-1:0]  count;
    } frame_res_t;

    // Length in bytes of a 7-bit-group varint; values stay below 2**21.
    function automatic logic [1:0] varint_len(input logic [CNT_W-1:0] v);
        logic [1:0] n;
        if (v < CNT_W'(128))
            n = 2'd1;
        else if (v < CNT_W'(16384))
            n = 2'd2;
        else
            n = 2'd3;
        return n;
    endfunction

endpackage

@@ hw/rtl/sps_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/sps_row_cell.sv @@
`timescale 1ns / 1ps
// One row of the prediction window: five taps plus a one-line delay to the next row.
// Depends on sps_pkg and sps_ram.
module sps_row_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  shift_en,
    input  logic [sps_pkg::PX_W-1:0]              din,
    input  logic [sps_pkg::XW-1:0]                wm1,
    output logic [sps_pkg::WIN_COLS-1:0][sps_pkg::PX_W-1:0] taps,
    output logic [sps_pkg::PX_W-1:0]              dout
);
    import sps_pkg::*;

    logic [WIN_COLS-1:0][PX_W-1:0] sr_reg;
    logic [XW-1:0]                 wp_reg;
    logic [PX_W-1:0]               line_q;
    logic [XW-1:0]                 raddr;

    // The word wanted at the next shift was written w-1 shifts before this one.
    assign raddr = wp_reg - wm1;

    sps_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_line (
        .clk   (clk),
        .we    (shift_en),
        .waddr (wp_reg),
        .wdata (din),
        .re    (shift_en),
        .raddr (raddr),
        .rdata (line_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else if (shift_en)
        begin
            wp_reg <= wp_reg + XW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sr_reg <= {sr_reg[WIN_COLS-2:0], din};
        end
    end

    assign taps = sr_reg;
    // A one-pixel line is just the previous input word.
    assign dout = (wm1 == '0) ? sr_reg[0] : line_q;

endmodule

@@ hw/rtl/sps_cand_cell.sv @@
`timescale 1ns / 1ps
// Patch-cost accumulator for one candidate shift.
// Depends on sps_pkg.
module sps_cand_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sps_pkg::pix_ctx_t          ctx,
    input  logic [sps_pkg::PX_W-1:0]   tap,
    input  logic signed [2:0]          dx,
    input  logic signed [2:0]          dy,
    input  logic                       clear,
    output sps_pkg::cand_tot_t         tot
);
    import sps_pkg::*;

    logic [COST_W-1:0] cost_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  last_reg;
    logic              first_reg;

    logic signed [XW+1:0] sx;
    logic signed [YW+1:0] sy;
    logic                 in_frame;
    logic [PX_W-1:0]      pred;
    logic                 hit;
    logic [POS_W-1:0]     gap;
    logic [COST_W-1:0]    cost_next;

    always_comb
    begin
        sx = $signed({2'b00, ctx.x}) - $signed({{(XW-1){dx[2]}}, dx});
        sy = $signed({2'b00, ctx.y}) - $signed({{(YW-1){dy[2]}}, dy});
        in_frame = !sx[XW+1] && (sx[XW:0] <= {1'b0, ctx.wm1})
                && !sy[YW+1] && (sy[YW:0] <= {1'b0, ctx.hm1});
        pred = in_frame ? tap : '0;
        hit  = ctx.valid && ctx.hp && (pred != ctx.px);
        gap  = first_reg ? ctx.pos : ctx.pos - last_reg;
        cost_next = cost_reg + COST_W'(varint_len(CNT_W'(gap))) + COST_W'(1);
        tot.cost  = hit ? cost_next : cost_reg;
        tot.count = hit ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg  <= '0;
            cnt_reg   <= '0;
            last_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (clear)
        begin
            cost_reg  <= '0;
            cnt_reg   <= '0;
            last_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (hit)
        begin
            cost_reg  <= cost_next;
            cnt_reg   <= tot.count;
            last_reg  <= ctx.pos;
            first_reg <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/sps_select.sv @@
`timescale 1ns / 1ps
// Frame-end mode decision: sweeps the 13 candidate totals, one per cycle.
// Depends on sps_pkg; keeps the last-sent-shift history.
module sps_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        hp,
    input  logic [sps_pkg::OUT_W-1:0]   raw_cost,
    input  sps_pkg::cand_tot_t          tots [sps_pkg::NUM_SHIFTS],
    input  logic                        out_free,
    input  logic                        clear_hist,
    output logic                        busy,
    output logic                        res_valid,
    output sps_pkg::frame_res_t         res
);
    import sps_pkg::*;

    sel_state_t state_reg, state_next;

    cand_tot_t         snap_reg [NUM_SHIFTS];
    logic              hp_reg;
    logic [K_W-1:0]    k_reg;
    logic [COST_W-1:0] best_cost_reg;
    mode_t             best_mode_reg;
    logic signed [2:0] best_x_reg, best_y_reg;
    logic [CNT_W-1:0]  best_cnt_reg;
    logic              shv_reg;
    logic signed [2:0] lx_reg, ly_reg;

    logic signed [2:0] kdx, kdy;
    logic              cont;
    logic [COST_W-1:0] c;
    logic              upd;

    always_comb
    begin
        kdx  = 3'(SHIFT_DX_I[k_reg]);
        kdy  = 3'(SHIFT_DY_I[k_reg]);
        cont = shv_reg && (kdx == lx_reg) && (kdy == ly_reg);
        c    = COST_W'(cont ? CONT_OVERHEAD : NEW_SHIFT_OVERHEAD)
             + COST_W'(varint_len(snap_reg[k_reg].count)) + snap_reg[k_reg].cost;
        upd  = hp_reg && (c < best_cost_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_valid  = 1'b0;
        case (state_reg)
            SEL_IDLE:
            begin
                if (start)
                begin
                    state_next = SEL_SWEEP;
                end
            end
            SEL_SWEEP:
            begin
                if (k_reg == K_W'(NUM_SHIFTS - 1))
                begin
                    state_next = SEL_DONE;
                end
            end
            SEL_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = SEL_IDLE;
                end
            end
            default:
            begin
                state_next = SEL_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != SEL_IDLE);

    always_ff @(posedge clk)
    begin
        if (start && state_reg == SEL_IDLE)
        begin
            snap_reg      <= tots;
            hp_reg        <= hp;
            k_reg         <= '0;
            best_cost_reg <= COST_W'(raw_cost);
            best_mode_reg <= MODE_RAW;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_cnt_reg  <= '0;
        end
        else if (state_reg == SEL_SWEEP)
        begin
            k_reg <= k_reg + K_W'(1);
            if (upd)
            begin
                best_cost_reg <= c;
                best_mode_reg <= cont ? MODE_CONT : MODE_SHIFT;
                best_x_reg    <= kdx;
                best_y_reg    <= kdy;
                best_cnt_reg  <= snap_reg[k_reg].count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shv_reg <= 1'b0;
            lx_reg  <= '0;
            ly_reg  <= '0;
        end
        else if (clear_hist)
        begin
            shv_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            case (best_mode_reg)
                MODE_RAW:
                begin
                    shv_reg <= 1'b0;
                end
                MODE_SHIFT:
                begin
                    shv_reg <= 1'b1;
                    lx_reg  <= best_x_reg;
                    ly_reg  <= best_y_reg;
                end
                default:
                begin
                    shv_reg <= shv_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res.mode  = best_mode_reg;
        res.sx    = best_x_reg;
        res.sy    = best_y_reg;
        res.bytes = best_cost_reg[OUT_W-1:0];
        res.count = best_cnt_reg;
    end

endmodule

@@ hw/rtl/shift_patch_mode_selector_top.sv @@
`timescale 1ns / 1ps
// Top level of the shift-patch mode selector: frame stores, window rows, accumulators.
// Depends on sps_pkg, sps_ram, sps_row_cell, sps_cand_cell and sps_select.
//
// Throughput: one pixel word per cycle inside a frame. After the last pixel of a frame
// the input pauses while the decision sweep runs (one candidate per cycle) and, once a
// previous frame exists, while the first 2*width+3 previous-frame pixels are fetched
// into the window; the longer of the two sets the pause. A result word still unread
// when the next decision finishes holds that decision, and the input.
// Reset: asynchronous, active low; clears control state, size registers go to 256x256.
module shift_patch_mode_selector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [sps_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sps_pkg::CFG_W-1:0]      cfg_data,
    // Pixel input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel
    input  logic                           s_tuser,   // [0] sequence_start
    // Result output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // [2:0] shift_x, [5:3] shift_y,
                                                      // [22:6] coded_bytes,
                                                      // [39:23] patch_count
    output logic [1:0]                     m_tuser    // [1:0] frame_mode
);
    import sps_pkg::*;

    // Size registers and their effective values (zero acts as one, large saturates).
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [XW-1:0]    wm1;
    logic [YW-1:0]    hm1;

    // Raster position of the next pixel and frame bookkeeping.
    logic [POS_W-1:0] pos_reg;
    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic             hp_reg;       // a complete previous frame is stored
    logic             bank_reg;     // frame store written by the current frame
    logic [RD_W-1:0]  rd_ptr_reg;   // next previous-frame address to fetch
    logic             pf_need_reg;  // window is being refilled for a new frame
    logic             rvalid_reg;
    logic             rd_bank_reg;

    // Compare stage.
    pix_ctx_t         s1_reg;
    logic             s1_last_reg;

    logic             accept;
    logic             seq;
    logic [POS_W-1:0] pos_eff;
    logic [XW-1:0]    x_eff;
    logic [YW-1:0]    y_eff;
    logic             hp_eff;
    logic             last_eff;
    logic             rd_en;
    logic             pf_last;
    logic             cand_clear;

    logic [PX_W-1:0]  q0, q1, prev_px;
    logic [WIN_ROWS-1:0][WIN_COLS-1:0][PX_W-1:0] win;
    logic [PX_W-1:0]  row_link [WIN_ROWS-1];

    cand_tot_t        tots [NUM_SHIFTS];
    logic             sel_busy;
    logic             res_valid;
    frame_res_t       res;
    logic             out_free;
    logic             out_valid_reg;
    frame_res_t       out_reg;

    // Effective frame size, held as size minus one.
    always_comb
    begin
        if (width_reg == '0)
            wm1 = '0;
        else if (width_reg > CFG_W'(MAX_WIDTH))
            wm1 = XW'(MAX_WIDTH - 1);
        else
            wm1 = XW'(width_reg - CFG_W'(1));
        if (height_reg == '0)
            hm1 = '0;
        else if (height_reg > CFG_W'(MAX_HEIGHT))
            hm1 = YW'(MAX_HEIGHT - 1);
        else
            hm1 = YW'(height_reg - CFG_W'(1));
    end

    // The input is held off while the window refills, while the last pixel of a frame
    // sits in the compare stage, and while the decision sweep runs or its result waits.
    assign s_tready = !pf_need_reg && !sel_busy && !(s1_reg.valid && s1_last_reg);
    assign accept   = s_tvalid && s_tready;

    // A sequence start makes the accepted pixel the first of a first frame.
    always_comb
    begin
        seq      = s_tuser;
        pos_eff  = seq ? '0 : pos_reg;
        x_eff    = seq ? '0 : x_reg;
        y_eff    = seq ? '0 : y_reg;
        hp_eff   = seq ? 1'b0 : hp_reg;
        last_eff = (x_eff == wm1) && (y_eff == hm1);
    end

    // The window must lead the current pixel by 2*width+2 previous-frame pixels: the
    // refill fetches that many plus one, then each pixel but the last fetches one.
    assign pf_last = (rd_ptr_reg == RD_W'({wm1, 1'b0}) + RD_W'(4));
    assign rd_en   = pf_need_reg || (accept && !last_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= CFG_W'(256);
            height_reg  <= CFG_W'(256);
            pos_reg     <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            hp_reg      <= 1'b0;
            bank_reg    <= 1'b0;
            rd_ptr_reg  <= '0;
            pf_need_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
            rd_bank_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rd_en;
            if (rd_en)
            begin
                rd_bank_reg <= ~bank_reg;
                rd_ptr_reg  <= rd_ptr_reg + RD_W'(1);
            end
            if (pf_need_reg && pf_last)
            begin
                pf_need_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
                pos_reg     <= '0;
                x_reg       <= '0;
                y_reg       <= '0;
                hp_reg      <= 1'b0;
                pf_need_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (last_eff)
                begin
                    // Frame complete: it becomes the previous frame.
                    pos_reg     <= '0;
                    x_reg       <= '0;
                    y_reg       <= '0;
                    hp_reg      <= 1'b1;
                    bank_reg    <= ~bank_reg;
                    rd_ptr_reg  <= '0;
                    pf_need_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_eff + POS_W'(1);
                    hp_reg  <= hp_eff;
                    if (x_eff == wm1)
                    begin
                        x_reg <= '0;
                        y_reg <= y_eff + YW'(1);
                    end
                    else
                    begin
                        x_reg <= x_eff + XW'(1);
                        y_reg <= y_eff;
                    end
                end
            end
        end
    end

    // Ping-pong frame stores: one takes the current frame, the other feeds the window.
    sps_ram #(.WIDTH(PX_W), .DEPTH(FRAME_DEPTH)) u_frame0 (
        .clk   (clk),
        .we    (accept && !bank_reg),
        .waddr (pos_eff),
        .wdata (s_tdata[PX_W-1:0]),
        .re    (rd_en),
        .raddr (rd_ptr_reg[POS_W-1:0]),
        .rdata (q0)
    );

    sps_ram #(.WIDTH(PX_W), .DEPTH(FRAME_DEPTH)) u_frame1 (
        .clk   (clk),
        .we    (accept && bank_reg),
        .waddr (pos_eff),
        .wdata (s_tdata[PX_W-1:0]),
        .re    (rd_en),
        .raddr (rd_ptr_reg[POS_W-1:0]),
        .rdata (q1)
    );

    assign prev_px = rd_bank_reg ? q1 : q0;

    // Chain of window rows; row r tap c holds the previous-frame pixel r*width+c words
    // behind the newest fetched one.
    genvar r;
    generate
        for (r = 0; r < WIN_ROWS; r++)
        begin : g_row
            if (r < WIN_ROWS - 1)
            begin : g_mid
                sps_row_cell u_row (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (rvalid_reg),
                    .din      ((r == 0) ? prev_px : row_link[(r == 0) ? 0 : r - 1]),
                    .wm1      (wm1),
                    .taps     (win[r]),
                    .dout     (row_link[r])
                );
            end
            else
            begin : g_end
                sps_row_cell u_row (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (rvalid_reg),
                    .din      (row_link[r - 1]),
                    .wm1      (wm1),
                    .taps     (win[r]),
                    .dout     ()
                );
            end
        end
    endgenerate

    // Compare stage register: the window has caught up with this pixel in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            s1_last_reg <= 1'b0;
        end
        else
        begin
            s1_reg.valid <= accept;
            if (accept)
            begin
                s1_reg.hp   <= hp_eff;
                s1_reg.px   <= s_tdata[PX_W-1:0];
                s1_reg.x    <= x_eff;
                s1_reg.y    <= y_eff;
                s1_reg.pos  <= pos_eff;
                s1_reg.wm1  <= wm1;
                s1_reg.hm1  <= hm1;
                s1_last_reg <= last_eff;
            end
        end
    end

    // Accumulators restart on a new sequence, a size change or a finished frame.
    assign cand_clear = cfg_we || (accept && seq) || (s1_reg.valid && s1_last_reg);

    genvar k;
    generate
        for (k = 0; k < NUM_SHIFTS; k++)
        begin : g_cand
            sps_cand_cell u_cand (
                .clk   (clk),
                .rst_n (rst_n),
                .ctx   (s1_reg),
                .tap   (win[2 + SHIFT_DY_I[k]][2 + SHIFT_DX_I[k]]),
                .dx    (3'(SHIFT_DX_I[k])),
                .dy    (3'(SHIFT_DY_I[k])),
                .clear (cand_clear),
                .tot   (tots[k])
            );
        end
    endgenerate

    // Decision sweep; raw costs one byte plus the pixel count (last pos + 1), so last pos + 2.
    sps_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s1_reg.valid && s1_last_reg),
        .hp         (s1_reg.hp),
        .raw_cost   (OUT_W'(s1_reg.pos) + OUT_W'(2)),
        .tots       (tots),
        .out_free   (out_free),
        .clear_hist (cfg_we || (accept && seq)),
        .busy       (sel_busy),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register: a waiting result stops the pixel stream only once the next decision is ready.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.mode;
    assign m_tdata  = {out_reg.count, out_reg.bytes, out_reg.sy, out_reg.sx};

    // No pixel may enter while the window is being refilled.
    assert property (@(posedge clk) disable iff (!rst_n) pf_need_reg |-> !s_tready)
        else $error("pixel accepted during window refill");

    // The last pixel of a frame always starts the decision sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && s1_last_reg && !sel_busy) |=> sel_busy)
        else $error("frame end did not start the decision sweep");

    // A finished frame restarts the raster and marks a stored previous frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_eff && !cfg_we) |=> (pos_reg == '0 && hp_reg && pf_need_reg))
        else $error("frame end bookkeeping wrong");

    // A result is only produced when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg) |-> m_tready)
        else $error("result overwrote a pending word");

endmodule

@@ tb/tb_shift_patch_mode_selector_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the shift-patch mode selector: streams frames, predicts the
// chosen coding of every frame and checks each result word. Depends on sps_pkg and the RTL.
module tb_shift_patch_mode_selector_top;
    import sps_pkg::*;

    // Expected coding of one frame.
    typedef struct {
        mode_t             mode;
        logic signed [2:0] sx;
        logic signed [2:0] sy;
        logic [16:0]       bytes;
        logic [16:0]       count;
    } frame_choice_t;

    // Frame mode predictor with its own copy of the frame stores and candidate tallies.
    class shift_mode_predictor;
        bit [7:0]      prior_px[65536];
        bit [7:0]      this_px[65536];
        bit [8:0]      width_reg;
        bit [8:0]      height_reg;
        int unsigned   pos;
        bit            has_prior;
        bit            sent_valid;
        int            sent_dx;
        int            sent_dy;
        longint        tally_count[NUM_SHIFTS];
        longint        tally_cost[NUM_SHIFTS];
        int unsigned   tally_last[NUM_SHIFTS];
        bit            tally_first[NUM_SHIFTS];
        frame_choice_t pending_choices[$];
        int            mismatches;
        int            frames_checked;
        int            mode_seen[3];

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            sent_dx    = 0;
            sent_dy    = 0;
            restart();
        endfunction

        function void restart();
            pos        = 0;
            has_prior  = 0;
            sent_valid = 0;
            for (int k = 0; k < NUM_SHIFTS; k++)
            begin
                tally_count[k] = 0;
                tally_cost[k]  = 0;
                tally_last[k]  = 0;
                tally_first[k] = 1;
            end
        endfunction

        function int unsigned varint_size(longint v);
            int unsigned n;
            n = 1;
            while (v >= 128)
            begin
                v = v >> 7;
                n++;
            end
            return n;
        endfunction

        function int unsigned used_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned used_height();
            if (height_reg == 0)
                return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_FRAME_WIDTH)
                width_reg = value;
            else
                height_reg = value;
            restart();
        endfunction

        // Called for every accepted pixel word.
        function void note_pixel(logic [7:0] px, logic start);
            int unsigned   w;
            int unsigned   h;
            int unsigned   cells;
            int            x;
            int            y;
            int            rx;
            int            ry;
            bit [7:0]      guess;
            longint        gap;
            longint        c;
            bit            cont;
            frame_choice_t pick;

            w = used_width();
            h = used_height();
            cells = w * h;
            if (start)
                restart();
            if (pos >= cells)
                pos = 0;
            x = pos % w;
            y = pos / w;
            this_px[pos] = px;
            if (has_prior)
            begin
                for (int k = 0; k < NUM_SHIFTS; k++)
                begin
                    rx = x - SHIFT_DX_I[k];
                    ry = y - SHIFT_DY_I[k];
                    guess = 0;
                    if (rx >= 0 && rx < w && ry >= 0 && ry < h)
                        guess = prior_px[ry * w + rx];
                    if (guess != px)
                    begin
                        gap = tally_first[k] ? pos : pos - tally_last[k];
                        tally_cost[k] += varint_size(gap) + 1;
                        tally_count[k]++;
                        tally_last[k] = pos;
                        tally_first[k] = 0;
                    end
                end
            end
            if (pos + 1 < cells)
            begin
                pos++;
                return;
            end

            // Frame complete: raw is the default, a shift wins only when strictly cheaper.
            pick.mode  = MODE_RAW;
            pick.sx    = 0;
            pick.sy    = 0;
            c          = 1 + cells;
            pick.count = 0;
            if (has_prior)
            begin
                for (int k = 0; k < NUM_SHIFTS; k++)
                begin
                    longint cand;
                    cont = sent_valid && SHIFT_DX_I[k] == sent_dx && SHIFT_DY_I[k] == sent_dy;
                    cand = (cont ? 1 : 5) + varint_size(tally_count[k]) + tally_cost[k];
                    if (cand < c)
                    begin
                        c          = cand;
                        pick.mode  = cont ? MODE_CONT : MODE_SHIFT;
                        pick.sx    = 3'(SHIFT_DX_I[k]);
                        pick.sy    = 3'(SHIFT_DY_I[k]);
                        pick.count = 17'(tally_count[k]);
                    end
                end
            end
            pick.bytes = 17'(c);
            if (pick.mode == MODE_RAW)
                sent_valid = 0;
            else if (pick.mode == MODE_SHIFT)
            begin
                sent_dx    = int'(pick.sx);
                sent_dy    = int'(pick.sy);
                sent_valid = 1;
            end
            pending_choices = {pending_choices, pick};
            for (int i = 0; i < cells; i++)
                prior_px[i] = this_px[i];
            has_prior = 1;
            pos = 0;
            for (int k = 0; k < NUM_SHIFTS; k++)
            begin
                tally_count[k] = 0;
                tally_cost[k]  = 0;
                tally_last[k]  = 0;
                tally_first[k] = 1;
            end
        endfunction

        // Called for every accepted result word.
        function void check_mode(logic [1:0] user, logic [39:0] data);
            frame_choice_t want;
            if (pending_choices.size() == 0)
            begin
                $error("result word with no frame pending: mode %0d data %h", user, data);
                mismatches++;
                return;
            end
            want = pending_choices.pop_front();
            frames_checked++;
            if (user < 3)
                mode_seen[user]++;
            if (user !== want.mode)
            begin
                $error("frame_mode: expected %0d, got %0d", want.mode, user);
                mismatches++;
            end
            if (data[2:0] !== want.sx)
            begin
                $error("shift_x: expected %0d, got %0d", want.sx, $signed(data[2:0]));
                mismatches++;
            end
            if (data[5:3] !== want.sy)
            begin
                $error("shift_y: expected %0d, got %0d", want.sy, $signed(data[5:3]));
                mismatches++;
            end
            if (data[22:6] !== want.bytes)
            begin
                $error("coded_bytes: expected %0d, got %0d", want.bytes, data[22:6]);
                mismatches++;
            end
            if (data[39:23] !== want.count)
            begin
                $error("patch_count: expected %0d, got %0d", want.count, data[39:23]);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [39:0]       m_tdata;
    logic [1:0]        m_tuser;

    shift_mode_predictor model;

    // Idle percentages of the current phase, for the sender and the receiver.
    int          send_idle_pct;
    int          recv_stall_pct;
    int          words_sent;
    // Generator copy of the last complete frame, used to build frames that shift well.
    bit [7:0]    gen_prior[65536];
    bit          gen_has_prior;
    int unsigned gen_w;
    int unsigned gen_h;

    shift_patch_mode_selector_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The run is cut off here if the block hangs; the normal end is far below this.
    initial
    begin
        #20_000_000;
        $display("tb_shift_patch_mode_selector_top: errors");
        $finish;
    end

    // Both monitors read the values that were present at the clock edge, so the
    // predictor sees each word exactly as the block accepted it.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            model.note_pixel(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            model.check_mode(m_tuser, m_tdata);
    end

    // The receiver stalls at random according to the phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one pixel word, with a random idle gap first, and waits for it to be taken.
    // The valid line stays high afterwards; the caller drops it when the stream pauses.
    task automatic send_word(input logic [7:0] px, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Waits until every expected result has come and the block has had time to settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (model.pending_choices.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Writes a size register; only called with the block idle.
    task automatic write_size(input logic [IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        model.write_reg(idx, CFG_W'(value));
        cfg_we    <= 1'b0;
        gen_w = model.used_width();
        gen_h = model.used_height();
        gen_has_prior = 0;
    endtask

    // Sends one frame, or the first `cut` pixels of it. Most frames copy the previous
    // frame under one of the shifts with a few stray pixels, so that shift and continue
    // decisions are exercised as well as raw.
    task automatic send_frame(input bit start, input int cut);
        int          style;
        int          k;
        int          miss_pct;
        int          x;
        int          y;
        int          rx;
        int          ry;
        int unsigned cells;
        bit [7:0]    px;
        bit [7:0]    fresh[65536];

        cells = gen_w * gen_h;
        style = $urandom_range(9);
        k = $urandom_range(NUM_SHIFTS - 1);
        miss_pct = ($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(8);
        if (start)
            gen_has_prior = 0;
        for (int p = 0; p < cells && p < cut; p++)
        begin
            x = p % gen_w;
            y = p / gen_w;
            rx = x - SHIFT_DX_I[k];
            ry = y - SHIFT_DY_I[k];
            px = 8'($urandom_range(255));
            if (gen_has_prior && style > 1 && $urandom_range(99) >= miss_pct)
                px = (rx >= 0 && rx < gen_w && ry >= 0 && ry < gen_h) ?
                     gen_prior[ry * gen_w + rx] : 8'd0;
            fresh[p] = px;
            send_word(px, start && p == 0);
        end
        if (cut >= cells)
        begin
            for (int p = 0; p < cells; p++)
                gen_prior[p] = fresh[p];
            gen_has_prior = 1;
        end
    endtask

    initial
    begin
        int size_w[6];
        int size_h[6];
        int budget;

        model = new();
        size_w = '{3, 1, 511, 4, 256, 2};
        size_h = '{2, 511, 1, 4, 2, 1};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        gen_has_prior  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: single-pixel frames (a zero width acts as one) with the
        // extreme pixel values, a first frame, repeated frames and sequence restarts.
        write_size(REG_FRAME_WIDTH, 0);
        write_size(REG_FRAME_HEIGHT, 1);
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'hAA, 1'b0);
        drain();
        // Two by two frames: a restart in the middle of a frame throws the partial away.
        write_size(REG_FRAME_WIDTH, 2);
        write_size(REG_FRAME_HEIGHT, 2);
        send_word(8'h01, 1'b1);
        send_word(8'h02, 1'b0);
        send_word(8'h03, 1'b1);
        for (int i = 0; i < 4; i++)
            send_word(8'(16 + i), 1'b0);
        for (int i = 0; i < 4; i++)
            send_word(8'(16 + i), 1'b0);
        drain();

        // Random phases: each pairs an idling pattern with a frame size, among them
        // the oversize register values that saturate to the largest width or height.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            write_size(REG_FRAME_WIDTH, size_w[ph % 6]);
            write_size(REG_FRAME_HEIGHT, size_h[ph % 6]);
            budget = words_sent + 170;
            send_frame(1'b1, 1 << 20);
            while (words_sent < budget)
            begin
                if ($urandom_range(19) == 0)
                begin
                    // Broken frame followed by a fresh sequence.
                    send_frame(1'b0, $urandom_range(gen_w * gen_h));
                    send_frame(1'b1, 1 << 20);
                end
                else
                    send_frame($urandom_range(29) == 0, 1 << 20);
                // Hold the stream until every pending frame has been reported.
                if ($urandom_range(15) == 0)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (model.pending_choices.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Sent %0d pixel words; checked %0d frame decisions (raw %0d, shift %0d, %s",
                 words_sent, model.frames_checked, model.mode_seen[0], model.mode_seen[1],
                 $sformatf("continue %0d) over sizes from 1x1 to 256x2.", model.mode_seen[2]));
        if (model.mismatches == 0)
            $display("tb_shift_patch_mode_selector_top: clean");
        else
            $display("tb_shift_patch_mode_selector_top: errors");
        $finish;
    end

endmodule

@@ shift_patch_mode_selector_top.f @@
hw/rtl/sps_pkg.sv
hw/rtl/sps_ram.sv
hw/rtl/sps_row_cell.sv
hw/rtl/sps_cand_cell.sv
hw/rtl/sps_select.sv
hw/rtl/shift_patch_mode_selector_top.sv
tb/tb_shift_patch_mode_selector_top.sv
